[rtl/cfb_pkg.sv]
// ----------------------------------------------------------------------------
// cfb_pkg
// Shared types and constants for the checksummed frame builder.
// ----------------------------------------------------------------------------
package cfb_pkg;

	localparam int BYTE_W = 8;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [BYTE_W-1:0] COUNT_MIN      = 8'd1;
	localparam logic [BYTE_W-1:0] COUNT_MAX      = 8'd249;
	localparam logic [BYTE_W-1:0] FRAME_OVERHEAD = 8'd6;

	// register indexes of the configuration port
	localparam logic [1:0] REG_HEADER_FIRST   = 2'd0;
	localparam logic [1:0] REG_HEADER_SECOND  = 2'd1;
	localparam logic [1:0] REG_TRAILER_FIRST  = 2'd2;
	localparam logic [1:0] REG_TRAILER_SECOND = 2'd3;

	localparam logic [BYTE_W-1:0] RST_HEADER_FIRST   = 8'h12;
	localparam logic [BYTE_W-1:0] RST_HEADER_SECOND  = 8'h34;
	localparam logic [BYTE_W-1:0] RST_TRAILER_FIRST  = 8'h1F;
	localparam logic [BYTE_W-1:0] RST_TRAILER_SECOND = 8'h2F;

	typedef struct packed {
		logic [BYTE_W-1:0] header_first;
		logic [BYTE_W-1:0] header_second;
		logic [BYTE_W-1:0] trailer_first;
		logic [BYTE_W-1:0] trailer_second;
	} cfg_t;

	// one classified payload byte, as handed from front to back
	typedef struct packed {
		logic              first;
		logic              last;
		logic [BYTE_W-1:0] data;
		logic [BYTE_W-1:0] len;
		logic [BYTE_W-1:0] sum;
	} entry_t;

	typedef enum logic [6:0] {
		ST_H1   = 7'b0000001,
		ST_H2   = 7'b0000010,
		ST_LEN  = 7'b0000100,
		ST_DATA = 7'b0001000,
		ST_SUM  = 7'b0010000,
		ST_T1   = 7'b0100000,
		ST_T2   = 7'b1000000
	} step_t;

endpackage

[rtl/cfb_front.sv]
// ----------------------------------------------------------------------------
// cfb_front
// Accepts payload bytes, tracks frame position and running checksum.
// ----------------------------------------------------------------------------
module cfb_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [cfb_pkg::BYTE_W-1:0]     payload_byte,
	input  logic [cfb_pkg::BYTE_W-1:0]     frame_count,
	input  logic                           q_full,
	output logic                           push,
	output cfb_pkg::entry_t                push_entry
);

	logic [cfb_pkg::BYTE_W-1:0] bytes_left_q;
	logic [cfb_pkg::BYTE_W-1:0] running_sum_q;
	logic [cfb_pkg::BYTE_W-1:0] count_clamped;
	logic [cfb_pkg::BYTE_W-1:0] len;
	logic [cfb_pkg::BYTE_W-1:0] left_base;
	logic [cfb_pkg::BYTE_W-1:0] sum_base;
	logic [cfb_pkg::BYTE_W-1:0] left_next;
	logic [cfb_pkg::BYTE_W-1:0] sum_next;
	logic                       starting;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;
	assign starting = (bytes_left_q == '0);

	always_comb begin
		count_clamped = frame_count;
		if (frame_count < cfb_pkg::COUNT_MIN) begin
			count_clamped = cfb_pkg::COUNT_MIN;
		end else if (frame_count > cfb_pkg::COUNT_MAX) begin
			count_clamped = cfb_pkg::COUNT_MAX;
		end
	end

	assign len       = count_clamped + cfb_pkg::FRAME_OVERHEAD;
	assign left_base = starting ? count_clamped : bytes_left_q;
	assign sum_base  = starting ? len : running_sum_q;
	assign left_next = left_base - 8'd1;
	assign sum_next  = sum_base + payload_byte;

	assign push_entry.first = starting;
	assign push_entry.last  = (left_next == '0);
	assign push_entry.data  = payload_byte;
	assign push_entry.len   = len;
	assign push_entry.sum   = sum_next;

	// advance frame position on each accepted item; drop the sum at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q  <= '0;
			running_sum_q <= '0;
		end else if (push) begin
			bytes_left_q  <= left_next;
			running_sum_q <= (left_next == '0) ? '0 : sum_next;
		end
	end

endmodule

[rtl/cfb_queue.sv]
// ----------------------------------------------------------------------------
// cfb_queue
// Short first-in first-out queue of classified entries.
// ----------------------------------------------------------------------------
module cfb_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cfb_pkg::entry_t push_entry,
	input  logic            pop,
	output cfb_pkg::entry_t head,
	output logic            full,
	output logic            empty
);

	cfb_pkg::entry_t                  slot_q [cfb_pkg::QDEPTH];
	logic [cfb_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [cfb_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [cfb_pkg::QCNT_W-1:0]       cnt_q;

	assign full  = (cnt_q == cfb_pkg::QCNT_W'(cfb_pkg::QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/cfb_back.sv]
// ----------------------------------------------------------------------------
// cfb_back
// Expands each entry into its output bytes, one per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module cfb_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfb_pkg::cfg_t              cfg,
	input  cfb_pkg::entry_t            head,
	input  logic                       empty,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [cfb_pkg::BYTE_W-1:0] out_byte,
	output logic                       frame_end,
	output logic                       run_last
);

	cfb_pkg::entry_t             cur_q;
	logic                        cur_valid_q;
	cfb_pkg::step_t              step_q;
	cfb_pkg::step_t              step_next;
	logic                        out_valid_q;
	logic [cfb_pkg::BYTE_W-1:0]  out_byte_q;
	logic                        frame_end_q;
	logic                        run_last_q;
	logic [cfb_pkg::BYTE_W-1:0]  emit_byte;
	logic                        entry_done;
	logic                        adv;

	assign adv        = !out_valid_q || out_ready;
	assign entry_done = ((step_q == cfb_pkg::ST_DATA) && !cur_q.last)
		|| (step_q == cfb_pkg::ST_T2);
	assign pop        = adv && !empty && (!cur_valid_q || entry_done);

	always_comb begin
		emit_byte = cur_q.data;
		step_next = cfb_pkg::ST_DATA;
		unique case (step_q)
			cfb_pkg::ST_H1: begin
				emit_byte = cfg.header_first;
				step_next = cfb_pkg::ST_H2;
			end
			cfb_pkg::ST_H2: begin
				emit_byte = cfg.header_second;
				step_next = cfb_pkg::ST_LEN;
			end
			cfb_pkg::ST_LEN: begin
				emit_byte = cur_q.len;
				step_next = cfb_pkg::ST_DATA;
			end
			cfb_pkg::ST_DATA: begin
				emit_byte = cur_q.data;
				step_next = cfb_pkg::ST_SUM;
			end
			cfb_pkg::ST_SUM: begin
				emit_byte = cur_q.sum;
				step_next = cfb_pkg::ST_T1;
			end
			cfb_pkg::ST_T1: begin
				emit_byte = cfg.trailer_first;
				step_next = cfb_pkg::ST_T2;
			end
			cfb_pkg::ST_T2: begin
				emit_byte = cfg.trailer_second;
				step_next = cfb_pkg::ST_H1;
			end
			default: begin
				emit_byte = cur_q.data;
				step_next = cfb_pkg::ST_DATA;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			step_q      <= cfb_pkg::ST_DATA;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= cur_valid_q;
			if (!cur_valid_q || entry_done) begin
				cur_valid_q <= !empty;
				step_q      <= head.first ? cfb_pkg::ST_H1 : cfb_pkg::ST_DATA;
			end else begin
				step_q <= step_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q  <= emit_byte;
			frame_end_q <= (step_q == cfb_pkg::ST_T2);
			run_last_q  <= entry_done;
			if (pop) begin
				cur_q <= head;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign frame_end = frame_end_q;
	assign run_last  = run_last_q;

endmodule

[rtl/checksummed_frame_builder_top.sv]
// ----------------------------------------------------------------------------
// checksummed_frame_builder_top
// Wraps payload bytes into header/length/payload/checksum/trailer frames.
// ----------------------------------------------------------------------------
// One payload item is accepted per cycle while the four-entry queue has room.
// Each item expands to one output byte, plus three (header pair and length)
// on a frame's first item and three (checksum and trailer pair) on its last,
// so a frame of n payload bytes leaves the block as n + 6 output bytes;
// the single output register of the back end gives one byte per cycle
// while out_ready allows. An accepted item passes through a queue slot,
// the back end's current-entry register and the output register. The
// front end tracks the bytes still expected and the running checksum, and
// classifies each item as first and/or last of its frame; the frame count
// is sampled only on a frame's first item and clamped to 1..249. run_last
// marks the final byte produced for an item and frame_end marks the second
// trailer byte. Configuration writes (header and trailer bytes) are taken
// at any cycle and must only be issued while no frame bytes are in flight.
module checksummed_frame_builder_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [cfb_pkg::BYTE_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [cfb_pkg::BYTE_W-1:0] payload_byte,
	input  logic [cfb_pkg::BYTE_W-1:0] frame_count,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [cfb_pkg::BYTE_W-1:0] out_byte,
	output logic                       frame_end,
	output logic                       run_last
);

	cfb_pkg::cfg_t   cfg_q;
	cfb_pkg::entry_t push_entry;
	cfb_pkg::entry_t head;
	logic            push;
	logic            pop;
	logic            q_full;
	logic            q_empty;

	// configuration registers: header and trailer bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_first   <= cfb_pkg::RST_HEADER_FIRST;
			cfg_q.header_second  <= cfb_pkg::RST_HEADER_SECOND;
			cfg_q.trailer_first  <= cfb_pkg::RST_TRAILER_FIRST;
			cfg_q.trailer_second <= cfb_pkg::RST_TRAILER_SECOND;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cfb_pkg::REG_HEADER_FIRST:   cfg_q.header_first   <= cfg_data;
				cfb_pkg::REG_HEADER_SECOND:  cfg_q.header_second  <= cfg_data;
				cfb_pkg::REG_TRAILER_FIRST:  cfg_q.trailer_first  <= cfg_data;
				cfb_pkg::REG_TRAILER_SECOND: cfg_q.trailer_second <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// front: accept and classify items
	cfb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.payload_byte (payload_byte),
		.frame_count  (frame_count),
		.q_full       (q_full),
		.push         (push),
		.push_entry   (push_entry)
	);

	// queue: decouple acceptance from output bursts
	cfb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.full       (q_full),
		.empty      (q_empty)
	);

	// back: expand each entry into framed output bytes
	cfb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.empty     (q_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.frame_end (frame_end),
		.run_last  (run_last)
	);

endmodule

[tb/checksummed_frame_builder_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// checksummed_frame_builder_top_test
// Self-checking bench for the checksummed frame builder.
// ----------------------------------------------------------------------------
// Feeds payload items through the valid/ready input, predicts the framed byte
// stream (header pair, length, payload, checksum, trailer pair) in a small
// scoreboard and compares every output byte field by field. Header and
// trailer registers are reprogrammed between phases at frame boundaries.
// ----------------------------------------------------------------------------
module checksummed_frame_builder_top_test;
	import cfb_pkg::*;

	localparam int SETTLE_CYCLES = 8;

	// Predicts the framed output stream and checks what the block emits.
	class frame_byte_scoreboard;
		typedef struct {
			logic [BYTE_W-1:0] data;
			logic              fend;
			logic              rlast;
		} stream_byte_t;

		cfg_t              regs;
		logic [BYTE_W-1:0] bytes_left;
		logic [BYTE_W-1:0] running_sum;
		stream_byte_t      expected_stream[$];
		int                mismatches;

		function new();
			regs.header_first   = RST_HEADER_FIRST;
			regs.header_second  = RST_HEADER_SECOND;
			regs.trailer_first  = RST_TRAILER_FIRST;
			regs.trailer_second = RST_TRAILER_SECOND;
			bytes_left  = '0;
			running_sum = '0;
			mismatches  = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [BYTE_W-1:0] value);
			case (idx)
				REG_HEADER_FIRST:   regs.header_first   = value;
				REG_HEADER_SECOND:  regs.header_second  = value;
				REG_TRAILER_FIRST:  regs.trailer_first  = value;
				REG_TRAILER_SECOND: regs.trailer_second = value;
				default: ;
			endcase
		endfunction

		function void push_byte(logic [BYTE_W-1:0] data, logic fend);
			stream_byte_t b;
			b.data  = data;
			b.fend  = fend;
			b.rlast = 1'b0;
			expected_stream.insert(expected_stream.size(), b);
		endfunction

		function void note_item(logic [BYTE_W-1:0] data, logic [BYTE_W-1:0] count);
			logic [BYTE_W-1:0] n;
			logic [BYTE_W-1:0] len;
			n = count;
			if (bytes_left == '0) begin
				if (n < COUNT_MIN) n = COUNT_MIN;
				if (n > COUNT_MAX) n = COUNT_MAX;
				len = n + FRAME_OVERHEAD;
				push_byte(regs.header_first, 1'b0);
				push_byte(regs.header_second, 1'b0);
				push_byte(len, 1'b0);
				running_sum = len;
				bytes_left  = n;
			end
			push_byte(data, 1'b0);
			running_sum = running_sum + data;
			bytes_left  = bytes_left - 1'b1;
			if (bytes_left == '0) begin
				push_byte(running_sum, 1'b0);
				push_byte(regs.trailer_first, 1'b0);
				push_byte(regs.trailer_second, 1'b1);
				running_sum = '0;
			end
			expected_stream[expected_stream.size() - 1].rlast = 1'b1;
		endfunction

		task report_mismatch(string what);
			mismatches++;
			$display("%0t ns mismatch: %s", $time, what);
		endtask

		task check_byte(logic [BYTE_W-1:0] data, logic fend, logic rlast);
			stream_byte_t want;
			if (expected_stream.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h", data));
				return;
			end
			want = expected_stream.pop_front();
			if (data !== want.data)
				report_mismatch($sformatf("out_byte %02h, want %02h", data, want.data));
			if (fend !== want.fend)
				report_mismatch($sformatf("frame_end %b, want %b", fend, want.fend));
			if (rlast !== want.rlast)
				report_mismatch($sformatf("run_last %b, want %b", rlast, want.rlast));
		endtask

		function int pending();
			return expected_stream.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [1:0]        cfg_index = REG_HEADER_FIRST;
	logic [BYTE_W-1:0] cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [BYTE_W-1:0] payload_byte = '0;
	logic [BYTE_W-1:0] frame_count = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [BYTE_W-1:0] out_byte;
	logic              frame_end;
	logic              run_last;

	frame_byte_scoreboard sb = new();

	// idle chances in percent, changed per phase
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int payload_items_sent = 0;

	checksummed_frame_builder_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.payload_byte (payload_byte),
		.frame_count  (frame_count),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.frame_end    (frame_end),
		.run_last     (run_last)
	);

	always #5 clk = ~clk;

	// Receiver: stall at random with the current idle chance.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Monitor: register writes, accepted items and output bytes all seen at the
	// same edge, so expectations are queued before any byte they cover.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.write_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				sb.note_item(payload_byte, frame_count);
			if (out_valid && out_ready)
				sb.check_byte(out_byte, frame_end, run_last);
		end
	end

	function automatic logic [BYTE_W-1:0] rand_byte();
		return BYTE_W'($urandom_range(255));
	endfunction

	// Offer one item, idling first at random; return at the edge that takes it.
	task automatic send_item(input logic [BYTE_W-1:0] data, input logic [BYTE_W-1:0] count);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		payload_byte <= data;
		frame_count  <= count;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		payload_items_sent++;
	endtask

	// Whole frame with random content; counts on later items are noise the
	// block must ignore, so give them the full 8-bit range.
	task automatic send_random_frame(input logic [BYTE_W-1:0] count);
		int n;
		n = (count < COUNT_MIN) ? COUNT_MIN : (count > COUNT_MAX) ? COUNT_MAX : count;
		send_item(rand_byte(), count);
		for (int i = 1; i < n; i++)
			send_item(rand_byte(), rand_byte());
	endtask

	// Mostly short frames so checksum and trailer handling show up often.
	function automatic logic [BYTE_W-1:0] pick_count();
		int r;
		r = $urandom_range(99);
		if (r < 6)
			return '0;
		if (r < 75)
			return BYTE_W'($urandom_range(1, 6));
		return BYTE_W'($urandom_range(7, 30));
	endfunction

	task automatic run_frames(input int goal);
		while (payload_items_sent < goal)
			send_random_frame(pick_count());
	endtask

	// Hold the input off until every predicted byte is out, then let the
	// pipeline go quiet.
	task automatic drain_frames();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input logic [1:0] idx, input logic [BYTE_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	// Program all four framing bytes back to back; call only between frames.
	task automatic set_framing(input logic [BYTE_W-1:0] h1, input logic [BYTE_W-1:0] h2,
			input logic [BYTE_W-1:0] t1, input logic [BYTE_W-1:0] t2);
		put_reg(REG_HEADER_FIRST, h1);
		put_reg(REG_HEADER_SECOND, h2);
		put_reg(REG_TRAILER_FIRST, t1);
		put_reg(REG_TRAILER_SECOND, t2);
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames on reset framing bytes
		tx_idle_pct = 32;
		rx_idle_pct = 70;
		send_item(8'h00, 8'd1);   // single-byte frame
		send_item(8'hFF, 8'd0);   // zero count taken as one
		send_item(8'hFF, 8'd2);
		send_item(8'hFF, 8'hFF);  // count mid-frame is ignored
		send_item(8'h80, 8'd3);
		send_item(8'h7F, 8'd0);
		send_item(8'h55, 8'h80);
		send_item(8'hAA, 8'd1);
		drain_frames();

		// all-zero framing bytes, checksum wraps past 0xFF
		set_framing(8'h00, 8'h00, 8'h00, 8'h00);
		send_item(8'hFF, 8'd1);
		send_item(8'hF0, 8'd3);
		send_item(8'hFF, 8'h7F);
		send_item(8'h11, 8'h01);
		drain_frames();

		// all-ones framing bytes
		set_framing(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_item(8'h01, 8'd2);
		send_item(8'hFE, 8'h00);
		send_item(8'h00, 8'd1);
		drain_frames();

		// random frames: sender idles lightly, receiver stalls hard
		set_framing(rand_byte(), rand_byte(), rand_byte(), rand_byte());
		run_frames(payload_items_sent + 40);
		drain_frames();   // sender waits out the whole backlog once
		run_frames(payload_items_sent + 40);
		drain_frames();

		// swap the idling sides; open with an oversized count clamped to 249
		tx_idle_pct = 70;
		rx_idle_pct = 32;
		set_framing(rand_byte(), rand_byte(), rand_byte(), rand_byte());
		send_random_frame(8'd255);
		run_frames(payload_items_sent + 20);
		drain_frames();

		// back-to-back traffic, no idling on either side
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_framing(rand_byte(), rand_byte(), rand_byte(), rand_byte());
		run_frames(payload_items_sent + 50);
		drain_frames();

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("** checksummed_frame_builder_top: PASSED **");
		else
			$display("** checksummed_frame_builder_top: FAILED **");
		$finish;
	end

	// Watchdog far above the slowest legal run.
	initial begin
		#2000000;
		$display("** checksummed_frame_builder_top: FAILED **");
		$finish;
	end

endmodule

[sim.f]
rtl/cfb_pkg.sv
rtl/cfb_front.sv
rtl/cfb_queue.sv
rtl/cfb_back.sv
rtl/checksummed_frame_builder_top.sv
tb/checksummed_frame_builder_top_test.sv
